[hdl/tbot_pkg.sv]
// ----------------------------------------------------------------------------
// tbot_pkg: shared types and codes for the typed box overlap table
// Box and table entry layouts, operation codes and field widths.
// ----------------------------------------------------------------------------
package tbot_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned SLOT_W = 4;
  // Edge sums are carried one bit wider than a position so they never wrap.
  localparam int unsigned EDGE_W = POS_W + 1;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_PLACE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } box_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    box_t              box;
  } entry_t;

endpackage

[hdl/tbot_mem.sv]
// ----------------------------------------------------------------------------
// tbot_mem: box table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tbot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tbot_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output tbot_pkg::entry_t rdata_o
);

  tbot_pkg::entry_t mem_q [DEPTH];
  tbot_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tbot_ovl.sv]
// ----------------------------------------------------------------------------
// tbot_ovl: box overlap compare unit
// Strictly positive area overlap test of two boxes; touching edges miss.
// ----------------------------------------------------------------------------
module tbot_ovl (
  input  tbot_pkg::box_t a_i,
  input  tbot_pkg::box_t b_i,
  output logic           hit_o
);

  logic signed [tbot_pkg::EDGE_W-1:0] a_l, a_t, a_r, a_b;
  logic signed [tbot_pkg::EDGE_W-1:0] b_l, b_t, b_r, b_b;

  always_comb begin
    a_l = tbot_pkg::EDGE_W'(a_i.x);
    a_t = tbot_pkg::EDGE_W'(a_i.y);
    b_l = tbot_pkg::EDGE_W'(b_i.x);
    b_t = tbot_pkg::EDGE_W'(b_i.y);
    a_r = a_l + $signed({2'b00, a_i.w});
    a_b = a_t + $signed({2'b00, a_i.h});
    b_r = b_l + $signed({2'b00, b_i.w});
    b_b = b_t + $signed({2'b00, b_i.h});
  end

  assign hit_o = (a_b > b_t) && (a_t < b_b) && (a_r > b_l) && (a_l < b_r);

endmodule

[hdl/typed_box_overlap_table_top.sv]
// ----------------------------------------------------------------------------
// typed_box_overlap_table_top: table of typed boxes with overlap query
// Place, remove and query items against a table of SLOTS boxes.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start_i high and busy_o low. Its
//   fields are mode_i, slot_i, pos_x_i, pos_y_i, width_i, height_i, kind_i.
//   Every item gives exactly one result: done_o is high for one cycle and
//   hit_o is valid in that cycle. Place, remove, unused modes, slots past
//   the table and queries from an empty slot all report hit 0.
// Sequencing:
//   Place and remove: the item is carried out in ST_EXEC, which registers
//   done_o; the next item can be taken while the result is shown.
//   Query: ST_EXEC reads the own entry, ST_LOAD writes the moved box back,
//   then ST_SCAN makes one table read and one overlap compare per cycle: the
//   scan walks every slot through the single read port of the box memory.
// Reset:
//   rst_ni clears all valid marks and the sequencer; box storage is not
//   cleared, an entry is only used after a place has written it.
// Output:
//   The receiver cannot stall; done_o is a strobe and must be taken as it
//   comes.
// ----------------------------------------------------------------------------
module typed_box_overlap_table_top #(
  parameter int SLOTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [tbot_pkg::MODE_W-1:0]           mode_i,
  input  logic [tbot_pkg::SLOT_W-1:0]           slot_i,
  input  logic signed [tbot_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [tbot_pkg::POS_W-1:0]     pos_y_i,
  input  logic [tbot_pkg::SIZE_W-1:0]           width_i,
  input  logic [tbot_pkg::SIZE_W-1:0]           height_i,
  input  logic [tbot_pkg::KIND_W-1:0]           kind_i,
  output logic                                  done_o,
  output logic                                  hit_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [8:0]       SLOTS_N  = 9'(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,   // dispatch the item, read own entry for a query
    ST_LOAD,   // take own size, write moved box back, start scan reads
    ST_SCAN    // one slot compared per cycle
  } state_e;

  state_e            state_q;
  logic [SLOTS-1:0]  valid_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              acc_q;
  logic              done_q;
  logic              hit_q;

  // latched item
  logic [tbot_pkg::MODE_W-1:0]       mode_q;
  logic [tbot_pkg::SLOT_W-1:0]       slot_q;
  logic signed [tbot_pkg::POS_W-1:0] x_q;
  logic signed [tbot_pkg::POS_W-1:0] y_q;
  logic [tbot_pkg::SIZE_W-1:0]       w_q;
  logic [tbot_pkg::SIZE_W-1:0]       h_q;
  logic [tbot_pkg::KIND_W-1:0]       kind_q;
  logic [tbot_pkg::SIZE_W-1:0]       own_w_q;
  logic [tbot_pkg::SIZE_W-1:0]       own_h_q;

  logic              accept;
  logic [8:0]        slot_ext;
  logic              in_range;
  logic [IDX_W-1:0]  slot_idx;
  logic              last;

  logic              mem_we;
  tbot_pkg::entry_t  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  tbot_pkg::entry_t  rd_entry;

  tbot_pkg::box_t    moved_box;
  logic              ovl_hit;
  logic              cand;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign slot_ext = {5'b0, slot_q};
  assign in_range = (slot_ext < SLOTS_N);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign last     = (cnt_q == LAST_IDX);

  // Memory port control: place writes a new entry, query writes back the
  // moved box with its stored size and kind.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_entry;
    mem_raddr = '0;
    unique case (state_q)
      ST_EXEC: begin
        mem_raddr = slot_idx;
        if (in_range && (mode_q == tbot_pkg::MODE_PLACE)) begin
          mem_we         = 1'b1;
          mem_wdata.kind = kind_q;
          mem_wdata.box  = '{x: x_q, y: y_q, w: w_q, h: h_q};
        end
      end
      ST_LOAD: begin
        mem_raddr       = '0;
        mem_we          = 1'b1;
        mem_wdata.kind  = rd_entry.kind;
        mem_wdata.box   = '{x: x_q, y: y_q, w: rd_entry.box.w, h: rd_entry.box.h};
      end
      ST_SCAN: begin
        mem_raddr = last ? '0 : cnt_q + 1'b1;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  tbot_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_idx),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_entry)
  );

  assign moved_box = '{x: x_q, y: y_q, w: own_w_q, h: own_h_q};

  tbot_ovl u_ovl (
    .a_i   (rd_entry.box),
    .b_i   (moved_box),
    .hit_o (ovl_hit)
  );

  // rd_entry holds slot cnt_q during the scan
  assign cand = valid_q[cnt_q] && (cnt_q != slot_idx) &&
                (rd_entry.kind == kind_q) && ovl_hit;

  // Sequencer, valid marks and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      cnt_q   <= '0;
      acc_q   <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          if (in_range) begin
            unique case (mode_q)
              tbot_pkg::MODE_PLACE:  valid_q[slot_idx] <= 1'b1;
              tbot_pkg::MODE_REMOVE: valid_q[slot_idx] <= 1'b0;
              tbot_pkg::MODE_QUERY: begin
                if (valid_q[slot_idx]) begin
                  state_q <= ST_LOAD;
                  done_q  <= 1'b0;
                  acc_q   <= 1'b0;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (last) begin
            done_q  <= 1'b1;
            hit_q   <= acc_q | cand;
            state_q <= ST_IDLE;
          end else begin
            acc_q <= acc_q | cand;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Item fields and own size of the querying box
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      w_q    <= width_i;
      h_q    <= height_i;
      kind_q <= kind_i;
    end
    if (state_q == ST_LOAD) begin
      own_w_q <= rd_entry.box.w;
      own_h_q <= rd_entry.box.h;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

  // A result strobe is never high in back-to-back cycles.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done strobe held for more than one cycle");

  // A hit is only reported together with a result strobe.
  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> done_q)
    else $error("hit without result strobe");

  // A hit only follows the last scan cycle.
  a_hit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> ($past(state_q) == ST_SCAN))
    else $error("hit reported without a scan");

  // Non-query items raise done_q as they leave ST_EXEC.
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i != tbot_pkg::MODE_QUERY)) |=> ##1 done_q)
    else $error("place or remove item did not finish in time");

endmodule

[verif/tb_typed_box_overlap_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_typed_box_overlap_table_top: self-checking bench for the box overlap table
// Feeds place, remove, query and unused-mode items through the start/busy
// handshake with random gaps, predicts every hit strobe from a shadow table
// kept in the bench, and compares each done_o strobe in order.
// ----------------------------------------------------------------------------
module tb_typed_box_overlap_table_top;

  localparam int SLOTS        = 16;
  localparam int N_RANDOM     = 1250;
  // Leave slack after the last strobe, scaled with the number of slots.
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int MAX_REPORTS  = 50;

  // Codes the package does not name.
  localparam logic [tbot_pkg::MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam logic [tbot_pkg::KIND_W-1:0] KIND_SOLID   = 2'd0;
  localparam logic [tbot_pkg::KIND_W-1:0] KIND_TRIGGER = 2'd1;
  localparam logic [tbot_pkg::KIND_W-1:0] KIND_FINISH  = 2'd2;
  localparam logic [tbot_pkg::KIND_W-1:0] KIND_SPARE   = 2'd3;

  // One item as the driver sees it, plus the idle cycles to hold before it.
  typedef struct {
    logic [tbot_pkg::MODE_W-1:0]       mode;
    logic [tbot_pkg::SLOT_W-1:0]       slot;
    logic signed [tbot_pkg::POS_W-1:0] x;
    logic signed [tbot_pkg::POS_W-1:0] y;
    logic [tbot_pkg::SIZE_W-1:0]       w;
    logic [tbot_pkg::SIZE_W-1:0]       h;
    logic [tbot_pkg::KIND_W-1:0]       kind;
    int unsigned                       idle;
  } item_t;

  // What the hit strobe of one item should show; mode and slot for messages.
  typedef struct {
    logic                        hit;
    logic [tbot_pkg::MODE_W-1:0] mode;
    logic [tbot_pkg::SLOT_W-1:0] slot;
  } hit_expect_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                              clk_i    = 1'b0;
  logic                              rst_ni   = 1'b0;
  logic                              start_i  = 1'b0;
  logic [tbot_pkg::MODE_W-1:0]       mode_i   = '0;
  logic [tbot_pkg::SLOT_W-1:0]       slot_i   = '0;
  logic signed [tbot_pkg::POS_W-1:0] pos_x_i  = '0;
  logic signed [tbot_pkg::POS_W-1:0] pos_y_i  = '0;
  logic [tbot_pkg::SIZE_W-1:0]       width_i  = '0;
  logic [tbot_pkg::SIZE_W-1:0]       height_i = '0;
  logic [tbot_pkg::KIND_W-1:0]       kind_i   = '0;
  logic                              busy_o;
  logic                              done_o;
  logic                              hit_o;

  typed_box_overlap_table_top #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .mode_i  (mode_i),
    .slot_i  (slot_i),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .width_i (width_i),
    .height_i(height_i),
    .kind_i  (kind_i),
    .done_o  (done_o),
    .hit_o   (hit_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow table: the bench's own copy of valid marks, boxes and kinds
  // --------------------------------------------------------------------------
  logic                        shadow_valid [SLOTS];
  tbot_pkg::box_t              shadow_box   [SLOTS];
  logic [tbot_pkg::KIND_W-1:0] shadow_kind  [SLOTS];

  item_t       pending_items [$];
  hit_expect_t hit_expect_q  [$];

  int unsigned n_place, n_remove, n_query, n_unused;
  int unsigned n_results, n_hits, fail_cnt;

  // Generator side: which slots the stimulus believes are live.
  logic gen_valid [SLOTS];
  logic burst_mode;

  // Strictly positive area overlap. Edges are summed in 32 bits, so the
  // 17-bit right/bottom edges never wrap. Touching edges give no overlap.
  function automatic logic boxes_cross(input tbot_pkg::box_t a, input tbot_pkg::box_t b);
    int ax, ay, aw, ah, bx, by, bw, bh;
    ax = int'($signed(a.x));
    ay = int'($signed(a.y));
    aw = int'(a.w);
    ah = int'(a.h);
    bx = int'($signed(b.x));
    by = int'($signed(b.y));
    bw = int'(b.w);
    bh = int'(b.h);
    if (ay + ah <= by) return 1'b0;
    if (ay >= by + bh) return 1'b0;
    if (ax + aw <= bx) return 1'b0;
    if (ax >= bx + bw) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one accepted item to the shadow table and return its hit value.
  function automatic logic table_apply(input item_t it);
    int   s;
    logic found;
    s     = int'(it.slot);
    found = 1'b0;
    if (s >= SLOTS) return 1'b0;
    case (it.mode)
      tbot_pkg::MODE_PLACE: begin
        shadow_box[s].x = it.x;
        shadow_box[s].y = it.y;
        shadow_box[s].w = it.w;
        shadow_box[s].h = it.h;
        shadow_kind[s]  = it.kind;
        shadow_valid[s] = 1'b1;
        n_place++;
      end
      tbot_pkg::MODE_REMOVE: begin
        shadow_valid[s] = 1'b0;
        n_remove++;
      end
      tbot_pkg::MODE_QUERY: begin
        n_query++;
        // Only a live slot moves; size stays as placed.
        if (shadow_valid[s]) begin
          shadow_box[s].x = it.x;
          shadow_box[s].y = it.y;
          for (int i = 0; i < SLOTS; i++) begin
            if (i != s && shadow_valid[i] && shadow_kind[i] == it.kind &&
                boxes_cross(shadow_box[i], shadow_box[s])) begin
              found = 1'b1;
            end
          end
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    return found;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Gap before an item: mostly none, some short, a few long. Burst stretches
  // run back to back so items land on every phase of a running query.
  function automatic int unsigned pick_idle();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_item(input logic [tbot_pkg::MODE_W-1:0] m, input int s, input int x,
                          input int y, input int w, input int h,
                          input logic [tbot_pkg::KIND_W-1:0] k);
    item_t it;
    it.mode = m;
    it.slot = s[tbot_pkg::SLOT_W-1:0];
    it.x    = x[tbot_pkg::POS_W-1:0];
    it.y    = y[tbot_pkg::POS_W-1:0];
    it.w    = w[tbot_pkg::SIZE_W-1:0];
    it.h    = h[tbot_pkg::SIZE_W-1:0];
    it.kind = k;
    it.idle = pick_idle();
    pending_items = {pending_items, it};
  endtask

  // Region picks where a box lives: a crowded window around the origin,
  // hugging the coordinate extremes, or anywhere in the 16-bit range.
  function automatic int rand_pos(input int region);
    if (region < 70) return $urandom_range(0, 160) - 80;
    if (region < 85) begin
      if ($urandom_range(0, 1)) return 32767 - $urandom_range(0, 100);
      return -32768 + $urandom_range(0, 100);
    end
    return int'($urandom);
  endfunction

  function automatic int rand_size(input int region);
    if (region < 70) begin
      if ($urandom_range(0, 19) == 0) return 0;
      return $urandom_range(1, 48);
    end
    if (region < 85 && $urandom_range(0, 1)) return 32767 - $urandom_range(0, 100);
    return $urandom_range(0, 32767);
  endfunction

  function automatic logic [tbot_pkg::KIND_W-1:0] rand_kind();
    int k;
    if ($urandom_range(0, 19) == 0) return KIND_SPARE;
    k = $urandom_range(0, 2);
    return k[tbot_pkg::KIND_W-1:0];
  endfunction

  // Mostly a slot the generator believes live; sometimes any slot.
  function automatic int pick_slot(input logic want_live);
    int s;
    s = $urandom_range(0, SLOTS - 1);
    if (!want_live) return s;
    for (int t = 0; t < 12; t++) begin
      if (gen_valid[s]) return s;
      s = $urandom_range(0, SLOTS - 1);
    end
    return s;
  endfunction

  task automatic build_directed();
    // Touching edges, a one-unit overlap and a kind mismatch.
    add_item(tbot_pkg::MODE_PLACE, 0, 0, 0, 10, 10, KIND_SOLID);
    add_item(tbot_pkg::MODE_PLACE, 1, 10, 0, 10, 10, KIND_SOLID);
    add_item(tbot_pkg::MODE_QUERY, 0, 0, 0, 0, 0, KIND_SOLID);
    add_item(tbot_pkg::MODE_QUERY, 0, 1, 0, 0, 0, KIND_SOLID);
    add_item(tbot_pkg::MODE_QUERY, 0, 1, 0, 0, 0, KIND_TRIGGER);
    add_item(tbot_pkg::MODE_QUERY, 0, 0, 10, 32767, 32767, KIND_SOLID);
    // Extreme corners and sizes: edge sums past the 16-bit range.
    add_item(tbot_pkg::MODE_PLACE, 2, -32768, -32768, 32767, 32767, KIND_TRIGGER);
    add_item(tbot_pkg::MODE_PLACE, 3, 32767, 32767, 32767, 32767, KIND_TRIGGER);
    add_item(tbot_pkg::MODE_QUERY, 3, -1, -1, 0, 0, KIND_TRIGGER);
    add_item(tbot_pkg::MODE_QUERY, 3, -2, -2, 0, 0, KIND_TRIGGER);
    add_item(tbot_pkg::MODE_QUERY, 3, 32767, 32767, 0, 0, KIND_TRIGGER);
    // Zero width and zero height boxes.
    add_item(tbot_pkg::MODE_PLACE, 4, 5, 5, 0, 10, KIND_FINISH);
    add_item(tbot_pkg::MODE_PLACE, 5, 0, 0, 100, 100, KIND_FINISH);
    add_item(tbot_pkg::MODE_PLACE, 8, 20, 20, 10, 0, KIND_FINISH);
    add_item(tbot_pkg::MODE_QUERY, 4, 5, 5, 0, 0, KIND_FINISH);
    add_item(tbot_pkg::MODE_QUERY, 5, 0, 0, 0, 0, KIND_FINISH);
    // Kind code three matches only itself.
    add_item(tbot_pkg::MODE_PLACE, 6, 50, 50, 10, 10, KIND_SPARE);
    add_item(tbot_pkg::MODE_QUERY, 5, 0, 0, 0, 0, KIND_SPARE);
    add_item(tbot_pkg::MODE_REMOVE, 6, 0, 0, 0, 0, KIND_SOLID);
    add_item(tbot_pkg::MODE_QUERY, 5, 0, 0, 0, 0, KIND_SPARE);
    // Remove and query of never-placed slots, unused mode, top slot.
    add_item(tbot_pkg::MODE_REMOVE, 7, 0, 0, 0, 0, KIND_SOLID);
    add_item(tbot_pkg::MODE_QUERY, 7, 0, 0, 0, 0, KIND_SOLID);
    add_item(MODE_UNUSED, 15, -1, -1, 32767, 32767, KIND_SPARE);
    add_item(tbot_pkg::MODE_PLACE, 15, 0, 0, 5, 5, KIND_SOLID);
    add_item(tbot_pkg::MODE_QUERY, 15, 2, 2, 0, 0, KIND_SOLID);
    foreach (gen_valid[i]) gen_valid[i] = 1'b0;
    foreach (gen_valid[i]) gen_valid[i] = (i inside {0, 1, 2, 3, 4, 5, 8, 15});
  endtask

  task automatic build_random(input int n);
    int r, region, s;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      r      = $urandom_range(0, 99);
      region = $urandom_range(0, 99);
      if (r < 35) begin
        s = pick_slot(1'b0);
        add_item(tbot_pkg::MODE_PLACE, s, rand_pos(region), rand_pos(region),
                 rand_size(region), rand_size(region), rand_kind());
        gen_valid[s] = 1'b1;
      end else if (r < 45) begin
        s = pick_slot($urandom_range(0, 3) != 0);
        add_item(tbot_pkg::MODE_REMOVE, s, int'($urandom), int'($urandom),
                 int'($urandom), int'($urandom), rand_kind());
        gen_valid[s] = 1'b0;
      end else if (r < 97) begin
        // Size fields are ignored by a query; drive them with noise.
        s = pick_slot($urandom_range(0, 9) != 0);
        add_item(tbot_pkg::MODE_QUERY, s, rand_pos(region), rand_pos(region),
                 int'($urandom), int'($urandom), rand_kind());
      end else begin
        add_item(MODE_UNUSED, $urandom_range(0, SLOTS - 1), int'($urandom),
                 int'($urandom), int'($urandom), int'($urandom), rand_kind());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: start_i stays up across back-to-back items, so it gets a single
  // nonblocking assignment per edge. Prediction happens at the accept edge.
  // --------------------------------------------------------------------------
  item_t       live_item;
  item_t       next_item;
  logic        have_next;
  int unsigned wait_left;
  logic        took;
  logic        launch;
  hit_expect_t fresh;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      mode_i    <= '0;
      slot_i    <= '0;
      pos_x_i   <= '0;
      pos_y_i   <= '0;
      width_i   <= '0;
      height_i  <= '0;
      kind_i    <= '0;
      have_next = 1'b0;
      wait_left = 0;
    end else begin
      took = start_i && !busy_o;
      if (took) begin
        fresh.hit  = table_apply(live_item);
        fresh.mode = live_item.mode;
        fresh.slot = live_item.slot;
        hit_expect_q = {hit_expect_q, fresh};
      end
      launch = 1'b0;
      if (took || !start_i) begin
        if (!have_next && pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          wait_left = next_item.idle;
          have_next = 1'b1;
        end
        if (have_next) begin
          if (wait_left == 0) launch = 1'b1;
          else wait_left--;
        end
      end
      if (launch) begin
        live_item = next_item;
        have_next = 1'b0;
        start_i   <= 1'b1;
        mode_i    <= next_item.mode;
        slot_i    <= next_item.slot;
        pos_x_i   <= next_item.x;
        pos_y_i   <= next_item.y;
        width_i   <= next_item.w;
        height_i  <= next_item.h;
        kind_i    <= next_item.kind;
      end else if (took) begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: done_o is a one-cycle strobe, matched in order against the
  // oldest predicted hit.
  // --------------------------------------------------------------------------
  hit_expect_t oldest;

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      n_results++;
      if (hit_o === 1'b1) n_hits++;
      if (hit_expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: strobe with no item outstanding: expected none, actual hit=%b",
                   $time, hit_o);
      end else begin
        oldest = hit_expect_q.pop_front();
        if (hit_o !== oldest.hit) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: hit mismatch (mode %0d slot %0d): expected %b, actual %b",
                     $time, oldest.mode, oldest.slot, oldest.hit, hit_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the item queue, release reset, wait for the drain
  // --------------------------------------------------------------------------
  initial begin
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    burst_mode = 1'b0;
    build_directed();
    build_random(N_RANDOM);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || have_next || start_i || hit_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Items: %0d place, %0d remove, %0d query, %0d unused mode.",
             n_place, n_remove, n_query, n_unused);
    $display("Strobes checked: %0d, %0d with a hit; %0d errors.", n_results, n_hits,
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard, well past the slowest correct run.
  initial begin
    #5ms;
    $display("%0t: timeout with %0d items queued, %0d strobes outstanding", $time,
             pending_items.size(), hit_expect_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
